// File: sv/priority_sorted_appointment_table_top_macros.svh
// Assertion helpers used by psat_ctrl.
`ifndef PRIORITY_SORTED_APPOINTMENT_TABLE_TOP_MACROS_SVH
`define PRIORITY_SORTED_APPOINTMENT_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PSAT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psat assertion failed");
`define PSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psat assertion failed");
`else
`define PSAT_ASSERT(label, clk, rst_n, prop)
`define PSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/psat_pkg.sv
`timescale 1ns / 1ps

package psat_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ZERO_ID   = 2'd3
  } status_e;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [10:0] duration;
  } payload_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    payload_t    payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0] mode;
    entry_t     ent;
  } request_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] count;
    logic [7:0] prio;
    payload_t   payload;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: sv/psat_ram.sv
`timescale 1ns / 1ps

module psat_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: sv/psat_ctrl.sv
`timescale 1ns / 1ps
`include "priority_sorted_appointment_table_top_macros.svh"

module psat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  psat_pkg::request_t  req_i,
  output psat_pkg::mem_req_t  mem_o,
  input  psat_pkg::entry_t    mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output psat_pkg::result_t   res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e                       st_q, st_d;
  logic [psat_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [psat_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                         found_q, found_d;
  psat_pkg::status_e            status_q, status_d;
  psat_pkg::request_t           req_q;
  psat_pkg::entry_t             hit_q, hit_d;
  logic                         accept;
  logic                         last;
  logic                         match;

  assign accept      = req_valid_i && (st_q == S_IDLE);
  assign req_ready_o = (st_q == S_IDLE);
  assign last  = (psat_pkg::CNT_W'(idx_q) + psat_pkg::CNT_W'(1)) >= cnt_q;
  assign match = (mem_rdata_i.id == req_q.ent.id);

  function automatic logic [psat_pkg::CNT_W-1:0] res_cnt(
    input logic [psat_pkg::CNT_W-1:0] cnt,
    input psat_pkg::status_e          status,
    input logic [1:0]                 mode
  );
    logic [psat_pkg::CNT_W-1:0] c;
    c = cnt;
    if (status == psat_pkg::ST_OK) begin
      if (mode == psat_pkg::MODE_INSERT) begin
        c = cnt + psat_pkg::CNT_W'(1);
      end else if (mode == psat_pkg::MODE_REMOVE) begin
        c = cnt - psat_pkg::CNT_W'(1);
      end
    end
    return c;
  endfunction

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    found_d  = found_q;
    status_d = status_q;
    hit_d    = hit_q;
    mem_o    = '0;
    case (st_q)
      S_IDLE: begin
        if (req_valid_i) begin
          found_d  = 1'b0;
          status_d = psat_pkg::ST_OK;
          hit_d    = '0;
          idx_d    = '0;
          case (req_i.mode)
            psat_pkg::MODE_INSERT: begin
              if (cnt_q == psat_pkg::CNT_W'(psat_pkg::DEPTH)) begin
                status_d = psat_pkg::ST_FULL;
                st_d     = S_DONE;
              end else if (cnt_q == '0) begin
                st_d = S_PUT;
              end else begin
                // shift from the tail towards the insertion point
                idx_d = psat_pkg::IDX_W'(cnt_q - psat_pkg::CNT_W'(1));
                st_d  = S_RD;
              end
            end
            psat_pkg::MODE_REMOVE: begin
              if (req_i.ent.id == '0) begin
                status_d = psat_pkg::ST_ZERO_ID;
                st_d     = S_DONE;
              end else if (cnt_q == '0) begin
                status_d = psat_pkg::ST_NOT_FOUND;
                st_d     = S_DONE;
              end else begin
                st_d = S_RD;
              end
            end
            psat_pkg::MODE_LOOKUP: begin
              if (cnt_q == '0) begin
                status_d = psat_pkg::ST_NOT_FOUND;
                st_d     = S_DONE;
              end else begin
                st_d = S_RD;
              end
            end
            default: st_d = S_DONE;
          endcase
        end
      end
      S_RD: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = idx_q;
        st_d        = S_EV;
      end
      S_EV: begin
        case (req_q.mode)
          psat_pkg::MODE_INSERT: begin
            mem_o.we    = 1'b1;
            mem_o.waddr = idx_q + psat_pkg::IDX_W'(1);
            if (mem_rdata_i.prio >= req_q.ent.prio) begin
              mem_o.wdata = mem_rdata_i;
              if (idx_q == '0) begin
                st_d = S_PUT;
              end else begin
                idx_d = idx_q - psat_pkg::IDX_W'(1);
                st_d  = S_RD;
              end
            end else begin
              mem_o.wdata = req_q.ent;
              st_d        = S_DONE;
            end
          end
          psat_pkg::MODE_REMOVE: begin
            if (found_q) begin
              // close the gap left by the removed entry
              mem_o.we    = 1'b1;
              mem_o.waddr = idx_q - psat_pkg::IDX_W'(1);
              mem_o.wdata = mem_rdata_i;
            end else if (match) begin
              found_d = 1'b1;
            end
            if (last) begin
              if (!(found_q || match)) begin
                status_d = psat_pkg::ST_NOT_FOUND;
              end
              st_d = S_DONE;
            end else begin
              idx_d = idx_q + psat_pkg::IDX_W'(1);
              st_d  = S_RD;
            end
          end
          default: begin
            if (match) begin
              hit_d = mem_rdata_i;
              st_d  = S_DONE;
            end else if (last) begin
              status_d = psat_pkg::ST_NOT_FOUND;
              st_d     = S_DONE;
            end else begin
              idx_d = idx_q + psat_pkg::IDX_W'(1);
              st_d  = S_RD;
            end
          end
        endcase
      end
      S_PUT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = idx_q;
        mem_o.wdata = req_q.ent;
        st_d        = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          cnt_d = res_cnt(cnt_q, status_q, req_q.mode);
          st_d  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign res_valid_o   = (st_q == S_DONE);
  assign res_o.status  = status_q;
  assign res_o.count   = 5'(res_cnt(cnt_q, status_q, req_q.mode));
  assign res_o.prio    = hit_q.prio;
  assign res_o.payload = hit_q.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      status_q <= psat_pkg::ST_OK;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    hit_q <= hit_d;
  end

  `PSAT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= psat_pkg::CNT_W'(psat_pkg::DEPTH))
  `PSAT_ASSERT_NEXT(a_cnt_hold, clk_i, rst_ni, !(st_q == S_DONE && res_ready_i), $stable(cnt_q))
  `PSAT_ASSERT(a_we_state, clk_i, rst_ni, mem_o.we |-> (st_q == S_EV || st_q == S_PUT))
  `PSAT_ASSERT(a_no_rw, clk_i, rst_ni, mem_o.we |-> !mem_o.re)

endmodule

// File: sv/priority_sorted_appointment_table_top.sv
`timescale 1ns / 1ps

// Sorted appointment table of psat_pkg::DEPTH entries held in one single-port-style
// memory (one write, one registered read per cycle). Each request is processed alone:
// a request is taken in the idle state, then every entry visited passes a read state,
// then an evaluate and write-back state. An insert visits, from the tail, each stored
// entry whose priority is equal or higher plus the first lower one that stops it, and
// writes the new entry in a separate put state when it lands at the head or the table
// is empty; a remove walks from the head to the last entry; a lookup walks from the
// head up to the first match. Full-table inserts, zero-id removes, empty-table searches
// and unused modes visit nothing. The result then waits in the done state until the
// output register is free, passes into it, and the next request is taken once the
// controller is back in idle, with the result already on the outputs by then. No
// clearing pass after reset: entries beyond the count are never read.
module priority_sorted_appointment_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] appt_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [11:0] year_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [10:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o,
  output logic [7:0]  found_priority_o,
  output logic [4:0]  found_day_o,
  output logic [3:0]  found_month_o,
  output logic [11:0] found_year_o,
  output logic [4:0]  found_hour_o,
  output logic [5:0]  found_minute_o,
  output logic [10:0] found_duration_o
);

  psat_pkg::request_t req;
  psat_pkg::mem_req_t mem_req;
  logic [psat_pkg::ENTRY_W-1:0] mem_rdata;
  psat_pkg::result_t  res;
  psat_pkg::result_t  out_q;
  logic               res_valid;
  logic               slot_free;
  logic               out_valid_q;

  assign req.mode                 = mode_i;
  assign req.ent.id               = appt_id_i;
  assign req.ent.prio             = priority_req_i;
  assign req.ent.payload.day      = day_i;
  assign req.ent.payload.month    = month_i;
  assign req.ent.payload.year     = year_i;
  assign req.ent.payload.hour     = hour_i;
  assign req.ent.payload.minute   = minute_i;
  assign req.ent.payload.duration = duration_i;

  psat_ram #(
    .DEPTH (psat_pkg::DEPTH),
    .WIDTH (psat_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  psat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .mem_o       (mem_req),
    .mem_rdata_i (psat_pkg::entry_t'(mem_rdata)),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .res_o       (res)
  );

  // output register: the next request is taken while a result waits here
  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign entry_count_o    = out_q.count;
  assign found_priority_o = out_q.prio;
  assign found_day_o      = out_q.payload.day;
  assign found_month_o    = out_q.payload.month;
  assign found_year_o     = out_q.payload.year;
  assign found_hour_o     = out_q.payload.hour;
  assign found_minute_o   = out_q.payload.minute;
  assign found_duration_o = out_q.payload.duration;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import psat_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LONG_HOLD     = 300;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 3 + 2 * DEPTH + 10;
  localparam int PHASE_ITEMS   = 480;
  localparam int BLOCK_ITEMS   = 40;

  localparam payload_t PAY_TOP  = '{day: 5'd31, month: 4'd12, year: 12'd4095,
                                    hour: 5'd23, minute: 6'd59, duration: 11'd1439};
  localparam payload_t PAY_ONES = '1;
  localparam payload_t PAY_ZERO = '0;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {BIAS_FILL, BIAS_MIX, BIAS_DRAIN} bias_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] id;
    logic [7:0]  prio;
    payload_t    pay;
  } booking_t;

  typedef struct {
    booking_t req;
    int       reps;
    bit       typed;
    result_t  want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [15:0] appt_id_i;
  logic [7:0]  priority_req_i;
  logic [4:0]  day_i;
  logic [3:0]  month_i;
  logic [11:0] year_i;
  logic [4:0]  hour_i;
  logic [5:0]  minute_i;
  logic [10:0] duration_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [4:0]  entry_count_o;
  logic [7:0]  found_priority_o;
  logic [4:0]  found_day_o;
  logic [3:0]  found_month_o;
  logic [11:0] found_year_o;
  logic [4:0]  found_hour_o;
  logic [5:0]  found_minute_o;
  logic [10:0] found_duration_o;

  priority_sorted_appointment_table_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .appt_id_i        (appt_id_i),
    .priority_req_i   (priority_req_i),
    .day_i            (day_i),
    .month_i          (month_i),
    .year_i           (year_i),
    .hour_i           (hour_i),
    .minute_i         (minute_i),
    .duration_i       (duration_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .found_priority_o (found_priority_o),
    .found_day_o      (found_day_o),
    .found_month_o    (found_month_o),
    .found_year_o     (found_year_o),
    .found_hour_o     (found_hour_o),
    .found_minute_o   (found_minute_o),
    .found_duration_o (found_duration_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the appointment table
  logic [15:0] slot_id   [DEPTH];
  logic [7:0]  slot_prio [DEPTH];
  payload_t    slot_pay  [DEPTH];
  int          slots_used = 0;

  result_t     pending_results[$];
  script_row_t script[$];

  idle_mode_e  idle_mode = IDLE_NONE;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  bit          cur_typed = 1'b0;
  result_t     cur_want = '0;
  int          failures = 0;
  int          stuck_cycles = 0;
  int          n_requests = 0, n_insert = 0, n_full = 0, n_remove = 0, n_zero = 0;
  int          n_lookup = 0, n_hit = 0, n_miss = 0, peak_used = 0;

  function automatic int first_slot(input logic [15:0] id);
    for (int i = 0; i < slots_used; i++)
      if (slot_id[i] == id) return i;
    return slots_used;
  endfunction

  function automatic result_t apply_booking(input booking_t b);
    result_t res;
    int      pos;
    res = '0;
    pos = 0;
    case (b.mode)
      MODE_INSERT: begin
        if (slots_used >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new entry goes in front of any entry of equal priority
          while (pos < slots_used && b.prio > slot_prio[pos]) pos++;
          for (int i = slots_used; i > pos; i--) begin
            slot_id[i]   = slot_id[i-1];
            slot_prio[i] = slot_prio[i-1];
            slot_pay[i]  = slot_pay[i-1];
          end
          slot_id[pos]   = b.id;
          slot_prio[pos] = b.prio;
          slot_pay[pos]  = b.pay;
          slots_used++;
        end
      end
      MODE_REMOVE: begin
        if (b.id == 16'd0) begin
          res.status = ST_ZERO_ID;
        end else begin
          pos = first_slot(b.id);
          if (pos >= slots_used) begin
            res.status = ST_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < slots_used; i++) begin
              slot_id[i]   = slot_id[i+1];
              slot_prio[i] = slot_prio[i+1];
              slot_pay[i]  = slot_pay[i+1];
            end
            slots_used--;
          end
        end
      end
      MODE_LOOKUP: begin
        pos = first_slot(b.id);
        if (pos >= slots_used) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.prio    = slot_prio[pos];
          res.payload = slot_pay[pos];
        end
      end
      default: ;
    endcase
    res.count = 5'(slots_used);
    return res;
  endfunction

  function automatic booking_t mk_booking(input logic [1:0] mode, input logic [15:0] id,
                                          input logic [7:0] prio, input payload_t pay);
    booking_t b;
    b.mode = mode;
    b.id   = id;
    b.prio = prio;
    b.pay  = pay;
    return b;
  endfunction

  function automatic result_t mk_result(input status_e st, input logic [4:0] count,
                                        input logic [7:0] prio, input payload_t pay);
    result_t r;
    r.status  = st;
    r.count   = count;
    r.prio    = prio;
    r.payload = pay;
    return r;
  endfunction

  function automatic void step_checked(input booking_t b, input result_t want);
    script_row_t row;
    row.req   = b;
    row.reps  = 1;
    row.typed = 1'b1;
    row.want  = want;
    script.push_back(row);
  endfunction

  function automatic void step_free(input booking_t b, input int reps);
    script_row_t row;
    row.req   = b;
    row.reps  = reps;
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  function automatic logic [15:0] rand_id();
    case ($urandom_range(9))
      0:       return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      1, 2, 3: return 16'($urandom);
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [7:0] rand_prio();
    case ($urandom_range(9))
      0:          return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      1, 2, 3, 4: return 8'($urandom);
      default:    return 8'($urandom_range(7));
    endcase
  endfunction

  function automatic payload_t rand_pay();
    payload_t p;
    if ($urandom_range(99) < 85) begin
      p.day      = 5'($urandom_range(31, 1));
      p.month    = 4'($urandom_range(12, 1));
      p.year     = 12'($urandom_range(4095));
      p.hour     = 5'($urandom_range(23));
      p.minute   = 6'($urandom_range(59));
      p.duration = 11'($urandom_range(1439));
    end else begin
      p = payload_t'($urandom ^ {$urandom, 11'd0});
    end
    return p;
  endfunction

  function automatic booking_t pick_booking(input bias_e bias);
    booking_t b;
    int       roll;
    int       ins_w;
    int       rem_w;
    b = mk_booking(MODE_INSERT, rand_id(), rand_prio(), rand_pay());
    case (bias)
      BIAS_FILL:  begin ins_w = 65; rem_w = 15; end
      BIAS_DRAIN: begin ins_w = 10; rem_w = 70; end
      default:    begin ins_w = 40; rem_w = 25; end
    endcase
    roll = $urandom_range(99);
    if (roll < ins_w)              b.mode = MODE_INSERT;
    else if (roll < ins_w + rem_w) b.mode = MODE_REMOVE;
    else if (roll < 96)            b.mode = MODE_LOOKUP;
    else                           b.mode = MODE_UNUSED;
    // mostly aim removes and lookups at ids that are really stored
    if (b.mode != MODE_INSERT && slots_used > 0 && $urandom_range(99) < 80)
      b.id = slot_id[$urandom_range(slots_used - 1)];
    else if (b.mode == MODE_REMOVE && $urandom_range(99) < 10)
      b.id = 16'd0;
    return b;
  endfunction

  function automatic bit sender_gap();
    return (idle_mode == IDLE_SEND && $urandom_range(99) < 45) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 34);
  endfunction

  function automatic bit receiver_stall();
    return (idle_mode == IDLE_RECV && $urandom_range(99) < 45) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 34);
  endfunction

  // entered and left at a falling edge
  task automatic offer_booking(input booking_t b, input bit typed, input result_t want);
    while (sender_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_typed = typed;
    cur_want  = want;
    in_valid_i     <= 1'b1;
    mode_i         <= b.mode;
    appt_id_i      <= b.id;
    priority_req_i <= b.prio;
    day_i          <= b.pay.day;
    month_i        <= b.pay.month;
    year_i         <= b.pay.year;
    hour_i         <= b.pay.hour;
    minute_i       <= b.pay.minute;
    duration_i     <= b.pay.duration;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !receiver_stall();
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    booking_t seen;
    result_t  want;
    result_t  got;
    bit       bad;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        seen = mk_booking(mode_i, appt_id_i, priority_req_i,
                          '{day_i, month_i, year_i, hour_i, minute_i, duration_i});
        want = apply_booking(seen);
        if (cur_typed) want = cur_want;
        pending_results.push_back(want);
        n_requests++;
        if (slots_used > peak_used) peak_used = slots_used;
        case (seen.mode)
          MODE_INSERT: begin
            n_insert++;
            if (want.status == ST_FULL) n_full++;
          end
          MODE_REMOVE: begin
            n_remove++;
            if (want.status == ST_ZERO_ID) n_zero++;
            if (want.status == ST_NOT_FOUND) n_miss++;
          end
          MODE_LOOKUP: begin
            n_lookup++;
            if (want.status == ST_OK) n_hit++;
            else n_miss++;
          end
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        got = mk_result(status_e'(status_o), entry_count_o, found_priority_o,
                        '{found_day_o, found_month_o, found_year_o, found_hour_o,
                          found_minute_o, found_duration_o});
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with nothing pending: status %0d count %0d",
                     $realtime, status_o, entry_count_o);
        end else begin
          want = pending_results.pop_front();
          bad = (got.status !== want.status) || (got.count !== want.count) ||
                (got.prio !== want.prio) ||
                (got.payload.day !== want.payload.day) ||
                (got.payload.month !== want.payload.month) ||
                (got.payload.year !== want.payload.year) ||
                (got.payload.hour !== want.payload.hour) ||
                (got.payload.minute !== want.payload.minute) ||
                (got.payload.duration !== want.payload.duration);
          if (bad) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: mismatch\n  expected st %0d cnt %0d pri %0d d %0d m %0d y %0d",
                        " h %0d mi %0d dur %0d\n  actual   st %0d cnt %0d pri %0d d %0d",
                        " m %0d y %0d h %0d mi %0d dur %0d"},
                       $realtime, want.status, want.count, want.prio, want.payload.day,
                       want.payload.month, want.payload.year, want.payload.hour,
                       want.payload.minute, want.payload.duration,
                       got.status, got.count, got.prio, got.payload.day,
                       got.payload.month, got.payload.year, got.payload.hour,
                       got.payload.minute, got.payload.duration);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no request moved for %0d cycles, %0d results outstanding",
                 $realtime, STUCK_LIMIT, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    booking_t b;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_INSERT;
    appt_id_i      = '0;
    priority_req_i = '0;
    day_i          = '0;
    month_i        = '0;
    year_i         = '0;
    hour_i         = '0;
    minute_i       = '0;
    duration_i     = '0;

    // empty table cases
    step_checked(mk_booking(MODE_LOOKUP, 16'd5, 8'd0, PAY_ZERO),
                 mk_result(ST_NOT_FOUND, 5'd0, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_REMOVE, 16'd0, 8'd0, PAY_ZERO),
                 mk_result(ST_ZERO_ID, 5'd0, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_REMOVE, 16'd7, 8'd0, PAY_ZERO),
                 mk_result(ST_NOT_FOUND, 5'd0, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_UNUSED, 16'hFFFF, 8'hFF, PAY_ONES),
                 mk_result(ST_OK, 5'd0, 8'd0, PAY_ZERO));
    // extremes of id, priority and payload
    step_checked(mk_booking(MODE_INSERT, 16'hFFFF, 8'hFF, PAY_TOP),
                 mk_result(ST_OK, 5'd1, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_LOOKUP, 16'hFFFF, 8'd0, PAY_ZERO),
                 mk_result(ST_OK, 5'd1, 8'hFF, PAY_TOP));
    step_checked(mk_booking(MODE_INSERT, 16'd0, 8'd0, PAY_ONES),
                 mk_result(ST_OK, 5'd2, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_LOOKUP, 16'd0, 8'hFF, PAY_ZERO),
                 mk_result(ST_OK, 5'd2, 8'd0, PAY_ONES));
    step_checked(mk_booking(MODE_REMOVE, 16'd0, 8'd0, PAY_ZERO),
                 mk_result(ST_ZERO_ID, 5'd2, 8'd0, PAY_ZERO));
    // equal priorities and duplicate ids
    step_free(mk_booking(MODE_INSERT, 16'h1234, 8'hFF, '{5'd3, 4'd4, 12'd345, 5'd6,
                                                        6'd7, 11'd89}), 1);
    step_free(mk_booking(MODE_INSERT, 16'h1234, 8'd0, '{5'd9, 4'd8, 12'd765, 5'd4,
                                                       6'd3, 11'd210}), 1);
    step_free(mk_booking(MODE_LOOKUP, 16'h1234, 8'd0, PAY_ZERO), 1);
    step_free(mk_booking(MODE_REMOVE, 16'h1234, 8'd0, PAY_ZERO), 1);
    step_free(mk_booking(MODE_LOOKUP, 16'h1234, 8'd0, PAY_ZERO), 1);
    // fill to the brim, then knock on a full table
    step_free(mk_booking(MODE_INSERT, 16'h0100, 8'd128, PAY_TOP), 13);
    step_checked(mk_booking(MODE_INSERT, 16'h5555, 8'd77, PAY_TOP),
                 mk_result(ST_FULL, 5'd16, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_LOOKUP, 16'h5555, 8'd0, PAY_ZERO),
                 mk_result(ST_NOT_FOUND, 5'd16, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_REMOVE, 16'd0, 8'd0, PAY_ZERO),
                 mk_result(ST_ZERO_ID, 5'd16, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_REMOVE, 16'hFFFF, 8'd0, PAY_ZERO),
                 mk_result(ST_OK, 5'd15, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_UNUSED, 16'h0101, 8'd0, PAY_ZERO),
                 mk_result(ST_OK, 5'd15, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_INSERT, 16'hAAAA, 8'd200, PAY_ZERO),
                 mk_result(ST_OK, 5'd16, 8'd0, PAY_ZERO));
    step_checked(mk_booking(MODE_LOOKUP, 16'hAAAA, 8'd0, PAY_ZERO),
                 mk_result(ST_OK, 5'd16, 8'd200, PAY_ZERO));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[k]) begin
      for (int r = 0; r < script[k].reps; r++) begin
        b = script[k].req;
        b.id   = b.id + 16'(r);
        b.prio = b.prio + 8'(r);
        offer_booking(b, script[k].typed, script[k].want);
      end
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_e'(p);
      // long output hold while requests keep coming, so the input backs up
      if (idle_mode == IDLE_NONE) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_booking(pick_booking(bias_e'((n / BLOCK_ITEMS) % 3)), 1'b0, '0);
      drain_results();
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d inserts (%0d refused on a full table), %0d removes,",
             n_requests, n_insert, n_full, n_remove);
    $display("%0d lookups (%0d hits), %0d zero-id removes, %0d misses, peak fill %0d of %0d",
             n_lookup, n_hit, n_zero, n_miss, peak_used, DEPTH);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: priority_sorted_appointment_table_top.f
+incdir+sv
sv/psat_pkg.sv
sv/psat_ram.sv
sv/psat_ctrl.sv
sv/priority_sorted_appointment_table_top.sv
verif/testbench.sv
